// ===== sv/mlr_pkg.sv =====
// Shared package of the midpoint line rasterizer: widths, item and state types,
// request and octant codes, and the per-octant direction tables.
// Depends on nothing; every other file of the block imports it.
package mlr_pkg;

   // Coordinate width and the widths that follow from it.
   localparam int COORD_BITS = 12;
   localparam int TWICE_BITS = COORD_BITS + 1;
   localparam int DEC_BITS   = COORD_BITS + 3;
   localparam int COLOUR_BITS = 32;

   typedef logic [COORD_BITS-1:0]  coord_type;
   typedef logic [TWICE_BITS-1:0]  twice_type;
   typedef logic signed [DEC_BITS-1:0] decision_type;
   typedef logic [COLOUR_BITS-1:0] colour_type;

   // Request codes carried in the req_type field.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   // Octants, named by major direction then minor direction (y grows downwards).
   typedef enum logic [2:0] {
      OCT_RIGHT_UP   = 3'd0,
      OCT_UP_RIGHT   = 3'd1,
      OCT_UP_LEFT    = 3'd2,
      OCT_LEFT_UP    = 3'd3,
      OCT_LEFT_DOWN  = 3'd4,
      OCT_DOWN_LEFT  = 3'd5,
      OCT_DOWN_RIGHT = 3'd6,
      OCT_RIGHT_DOWN = 3'd7
   } octant_type;

   // One input item.
   typedef struct packed {
      logic       req_type;
      coord_type  start_x;
      coord_type  start_y;
      coord_type  end_x;
      coord_type  end_y;
      colour_type line_colour;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic       pixel_valid;
      coord_type  pixel_x;
      coord_type  pixel_y;
      colour_type pixel_colour;
      logic       last_pixel;
   } rsp_item_type;

   // State of the line being drawn.
   typedef struct packed {
      logic         busy;
      coord_type    cur_x;
      coord_type    cur_y;
      coord_type    steps;
      decision_type dec;
      twice_type    tmaj;
      twice_type    tmin;
      octant_type   oct;
      colour_type   colour;
   } line_state_type;

   // True when y is the major axis of the octant.
   function automatic logic oct_y_major(input octant_type oct);
      logic r;
      unique case (oct)
         OCT_UP_RIGHT, OCT_UP_LEFT, OCT_DOWN_LEFT, OCT_DOWN_RIGHT: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // True when x decreases along the line.
   function automatic logic oct_x_down(input octant_type oct);
      logic r;
      unique case (oct)
         OCT_UP_LEFT, OCT_LEFT_UP, OCT_LEFT_DOWN, OCT_DOWN_LEFT: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // True when y decreases along the line.
   function automatic logic oct_y_down(input octant_type oct);
      logic r;
      unique case (oct)
         OCT_RIGHT_UP, OCT_UP_RIGHT, OCT_UP_LEFT, OCT_LEFT_UP: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // Moves a coordinate by one, wrapping at the coordinate width.
   function automatic coord_type step_coord(input coord_type c, input logic down);
      return down ? c - coord_type'(1) : c + coord_type'(1);
   endfunction

endpackage

// ===== sv/mlr_if.sv =====
// Valid/ready channel interfaces for the request and result items of the
// midpoint line rasterizer. Depends on mlr_pkg for the item types.

interface mlr_req_if;
   import mlr_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type item;
   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface mlr_rsp_if;
   import mlr_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

// ===== sv/midpoint_line_rasterizer_core.sv =====
// Midpoint line rasterizer, all octants: one result item per request item.
// A request item waits in the input register until the result register is free.
// Throughput: one item per cycle unless the result side stalls; each step is a single add, compare and increment.
// Reset (synchronous, active high) empties both registers and clears the line state.
// Depends on mlr_pkg, mlr_if, mlr_setup and mlr_step.
module midpoint_line_rasterizer_core (
   input  logic          clock,
   input  logic          reset,
   mlr_req_if.sink       req_port,
   mlr_rsp_if.source     rsp_port
);
   import mlr_pkg::*;

   logic           in_valid_ff;
   logic           in_valid_in;
   req_item_type   in_item_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_item_type   rsp_item_ff;
   rsp_item_type   rsp_item_in;
   line_state_type line_ff;
   line_state_type line_in;
   line_state_type setup_line;
   line_state_type step_line;
   logic           out_free;
   logic           in_fire;
   logic           is_start;

   mlr_setup u_setup (.item(in_item_ff), .line(setup_line));
   mlr_step  u_step  (.cur(line_ff), .nxt(step_line));

   // Handshake: the input register moves on whenever the result register is free.
   always_comb begin
      out_free       = !rsp_valid_ff || rsp_port.ready;
      in_fire        = in_valid_ff && out_free;
      req_port.ready = !in_valid_ff || out_free;
      in_valid_in    = (req_port.valid && req_port.ready) ? 1'b1
                     : (in_fire ? 1'b0 : in_valid_ff);
      rsp_valid_in   = in_fire ? 1'b1 : (rsp_port.ready ? 1'b0 : rsp_valid_ff);
   end

   // Next line state and the result item of the registered request.
   always_comb begin
      is_start    = in_item_ff.req_type == REQ_START;
      line_in     = line_ff;
      rsp_item_in = '0;
      if (is_start) begin
         line_in = setup_line;
      end else if (line_ff.busy) begin
         line_in = step_line;
      end
      if (is_start || line_ff.busy) begin
         rsp_item_in.pixel_valid  = 1'b1;
         rsp_item_in.pixel_x      = line_in.cur_x;
         rsp_item_in.pixel_y      = line_in.cur_y;
         rsp_item_in.pixel_colour = line_in.colour;
         rsp_item_in.last_pixel   = !line_in.busy;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         line_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (in_fire) begin
            line_ff <= line_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         in_item_ff <= req_port.item;
      end
      if (in_fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.item  = rsp_item_ff;

endmodule

// ===== sv/mlr_setup.sv =====
// Line setup: picks the octant of a new line and forms its initial state.
// Purely combinational. Depends on mlr_pkg.
module mlr_setup (
   input  mlr_pkg::req_item_type   item,
   output mlr_pkg::line_state_type line
);
   import mlr_pkg::*;

   coord_type  aw;
   coord_type  ah;
   coord_type  maj;
   coord_type  mnr;
   logic       w_pos;
   logic       w_neg;
   logic       h_pos;
   logic       h_neg;
   octant_type oct;

   // Signs and magnitudes of the endpoint deltas.
   always_comb begin
      w_pos = item.end_x > item.start_x;
      w_neg = item.end_x < item.start_x;
      h_pos = item.end_y > item.start_y;
      h_neg = item.end_y < item.start_y;
      aw = w_neg ? item.start_x - item.end_x : item.end_x - item.start_x;
      ah = h_neg ? item.start_y - item.end_y : item.end_y - item.start_y;
   end

   // Octant choice; the order of the tests settles the boundary cases.
   always_comb begin
      if (w_pos && !h_pos) begin
         oct = (aw >= ah) ? OCT_RIGHT_UP : OCT_UP_RIGHT;
      end else if (!w_pos && !h_pos) begin
         oct = (aw < ah) ? OCT_UP_LEFT : OCT_LEFT_UP;
      end else if (w_neg && !h_neg) begin
         oct = (aw > ah) ? OCT_LEFT_DOWN : OCT_DOWN_LEFT;
      end else begin
         oct = (aw < ah) ? OCT_DOWN_RIGHT : OCT_RIGHT_DOWN;
      end
   end

   // Initial decision value and step counts.
   always_comb begin
      maj = oct_y_major(oct) ? ah : aw;
      mnr = oct_y_major(oct) ? aw : ah;
      line.busy   = maj != '0;
      line.cur_x  = item.start_x;
      line.cur_y  = item.start_y;
      line.steps  = maj;
      line.tmaj   = {maj, 1'b0};
      line.tmin   = {mnr, 1'b0};
      line.dec    = $signed({{(DEC_BITS-COORD_BITS-1){1'b0}}, mnr, 1'b0})
                  - $signed({{(DEC_BITS-COORD_BITS){1'b0}}, maj});
      line.oct    = oct;
      line.colour = item.line_colour;
   end

endmodule

// ===== sv/mlr_step.sv =====
// One midpoint step: advances the major axis, and the minor axis when the
// decision value is above zero. Purely combinational. Depends on mlr_pkg.
module mlr_step (
   input  mlr_pkg::line_state_type cur,
   output mlr_pkg::line_state_type nxt
);
   import mlr_pkg::*;

   logic         ymaj;
   logic         dec_pos;
   decision_type tmaj_ext;
   decision_type tmin_ext;

   always_comb begin
      ymaj     = oct_y_major(cur.oct);
      dec_pos  = !cur.dec[DEC_BITS-1] && (cur.dec != '0);
      tmaj_ext = $signed({{(DEC_BITS-TWICE_BITS){1'b0}}, cur.tmaj});
      tmin_ext = $signed({{(DEC_BITS-TWICE_BITS){1'b0}}, cur.tmin});

      nxt = cur;
      // The major axis always moves; the minor one only on a positive decision.
      if (!ymaj || dec_pos) begin
         nxt.cur_x = step_coord(cur.cur_x, oct_x_down(cur.oct));
      end
      if (ymaj || dec_pos) begin
         nxt.cur_y = step_coord(cur.cur_y, oct_y_down(cur.oct));
      end
      nxt.dec   = dec_pos ? cur.dec - tmaj_ext + tmin_ext : cur.dec + tmin_ext;
      nxt.steps = cur.steps - coord_type'(1);
      nxt.busy  = nxt.steps != '0;
   end

endmodule

// ===== sv/mlr_checker.sv =====
// Port-level checks of the midpoint line rasterizer, bound to the top level.
// Depends on mlr_pkg and midpoint_line_rasterizer_core.
module mlr_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input mlr_pkg::rsp_item_type rsp_item
);
   import mlr_pkg::*;

   // A stalled result item keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // After an accepted item a result is shown, either a stalled one holding the input
   // register back or the new one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##[0:1] rsp_valid)
      else $error("no result after an accepted item");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Only a real pixel can close a line.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_pixel |-> rsp_item.pixel_valid)
      else $error("last pixel flagged on an empty result");

   // A step while idle gives an all-zero result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.pixel_valid |->
         rsp_item.pixel_x == '0 && rsp_item.pixel_y == '0 && rsp_item.pixel_colour == '0)
      else $error("empty result carries pixel data");

endmodule

bind midpoint_line_rasterizer_core mlr_checker u_mlr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_port.valid),
   .req_ready (req_port.ready),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_item  (rsp_port.item)
);

// ===== test/mlr_line_checker.sv =====
// Checker for the midpoint line rasterizer: watches the request and result channels,
// works out each expected pixel from its own copy of the line state and compares.
// Depends on mlr_pkg for the item types and octant codes, and on mlr_if.
module mlr_line_checker (
   input  logic        clock,
   input  logic        reset,
   mlr_req_if          req_mon,
   mlr_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending
);
   import mlr_pkg::*;

   // Line state as the block should hold it.
   logic         line_busy;
   coord_type    pen_x;
   coord_type    pen_y;
   coord_type    pixels_left;
   decision_type err_term;
   twice_type    two_major;
   twice_type    two_minor;
   octant_type   line_oct;
   colour_type   line_colour_q;

   rsp_item_type pixel_queue[$];
   int unsigned  errs = 0;

   assign fail_count = errs;

   // The major axis is y in the four steep octants.
   function automatic bit y_is_major(input octant_type o);
      case (o)
         OCT_UP_RIGHT, OCT_UP_LEFT, OCT_DOWN_LEFT, OCT_DOWN_RIGHT: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit x_falls(input octant_type o);
      case (o)
         OCT_UP_LEFT, OCT_LEFT_UP, OCT_LEFT_DOWN, OCT_DOWN_LEFT: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit y_falls(input octant_type o);
      case (o)
         OCT_RIGHT_UP, OCT_UP_RIGHT, OCT_UP_LEFT, OCT_LEFT_UP: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic coord_type nudge(input coord_type c, input bit down);
      return down ? coord_type'(c - 1'b1) : coord_type'(c + 1'b1);
   endfunction

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // Advances the line state by one request item and gives the pixel it causes.
   task automatic next_pixel(input req_item_type rq, output rsp_item_type px);
      int w;
      int h;
      int maj;
      int mnr;
      bit at_end;
      if (rq.req_type == REQ_START) begin
         w = int'(rq.end_x) - int'(rq.start_x);
         h = int'(rq.end_y) - int'(rq.start_y);
         // Octant from the signs and sizes of the two deltas.
         if (w > 0 && h <= 0) begin
            line_oct = (w >= -h) ? OCT_RIGHT_UP : OCT_UP_RIGHT;
         end else if (w <= 0 && h <= 0) begin
            line_oct = (-w < -h) ? OCT_UP_LEFT : OCT_LEFT_UP;
         end else if (w < 0 && h >= 0) begin
            line_oct = (-w > h) ? OCT_LEFT_DOWN : OCT_DOWN_LEFT;
         end else begin
            line_oct = (w < h) ? OCT_DOWN_RIGHT : OCT_RIGHT_DOWN;
         end
         if (y_is_major(line_oct)) begin
            maj = magnitude(h);
            mnr = magnitude(w);
         end else begin
            maj = magnitude(w);
            mnr = magnitude(h);
         end
         two_major     = twice_type'(2 * maj);
         two_minor     = twice_type'(2 * mnr);
         err_term      = decision_type'(2 * mnr - maj);
         pixels_left   = coord_type'(maj);
         pen_x         = rq.start_x;
         pen_y         = rq.start_y;
         line_colour_q = rq.line_colour;
         at_end        = (pixels_left == '0);
         line_busy     = !at_end;
      end else if (!line_busy) begin
         // A step with no line running gives an empty item and changes nothing.
         px = '0;
         return;
      end else begin
         // The minor axis moves only while the decision value is above zero.
         if (err_term > 0) begin
            if (y_is_major(line_oct)) begin
               pen_x = nudge(pen_x, x_falls(line_oct));
            end else begin
               pen_y = nudge(pen_y, y_falls(line_oct));
            end
            err_term = err_term - decision_type'(two_major);
         end
         err_term = err_term + decision_type'(two_minor);
         if (y_is_major(line_oct)) begin
            pen_y = nudge(pen_y, y_falls(line_oct));
         end else begin
            pen_x = nudge(pen_x, x_falls(line_oct));
         end
         pixels_left = pixels_left - 1'b1;
         at_end      = (pixels_left == '0);
         line_busy   = !at_end;
      end
      px.pixel_valid  = 1'b1;
      px.pixel_x      = pen_x;
      px.pixel_y      = pen_y;
      px.pixel_colour = line_colour_q;
      px.last_pixel   = at_end;
   endtask

   // Predict on each accepted request, then compare each accepted result.
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         line_busy     = 1'b0;
         pen_x         = '0;
         pen_y         = '0;
         pixels_left   = '0;
         err_term      = '0;
         two_major     = '0;
         two_minor     = '0;
         line_oct      = OCT_RIGHT_UP;
         line_colour_q = '0;
         pixel_queue.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            next_pixel(req_mon.item, want);
            pixel_queue.push_back(want);
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got = rsp_mon.item;
            if (pixel_queue.size() == 0) begin
               $display("%0t: pixel with none expected: valid=%0d x=%0d y=%0d colour=%h last=%0d",
                        $time, got.pixel_valid, got.pixel_x, got.pixel_y,
                        got.pixel_colour, got.last_pixel);
               errs++;
            end else begin
               want = pixel_queue.pop_front();
               if (got.pixel_valid !== want.pixel_valid || got.pixel_x !== want.pixel_x ||
                   got.pixel_y !== want.pixel_y || got.pixel_colour !== want.pixel_colour ||
                   got.last_pixel !== want.last_pixel) begin
                  $display("%0t: pixel mismatch: expected valid=%0d x=%0d y=%0d colour=%h last=%0d",
                           $time, want.pixel_valid, want.pixel_x, want.pixel_y,
                           want.pixel_colour, want.last_pixel);
                  $display("%0t:                  actual valid=%0d x=%0d y=%0d colour=%h last=%0d",
                           $time, got.pixel_valid, got.pixel_x, got.pixel_y,
                           got.pixel_colour, got.last_pixel);
                  errs++;
               end
            end
         end
      end
      pending <= pixel_queue.size();
   end

endmodule

// ===== test/tb_midpoint_line_rasterizer_core.sv =====
// Testbench top for the midpoint line rasterizer: drives short directed lines, then
// random lines of all octants and lengths, with random gaps on both channels.
// Depends on mlr_pkg, mlr_if, the block itself and mlr_line_checker.
module tb_midpoint_line_rasterizer_core;
   import mlr_pkg::*;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending;
   int unsigned sent = 0;
   int unsigned gap_odds = 0;
   int unsigned stall_odds = 4;
   bit          calm = 1'b0;

   mlr_req_if req_ch ();
   mlr_rsp_if rsp_ch ();

   midpoint_line_rasterizer_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   mlr_line_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request item with every field random; callers overwrite what matters.
   function automatic req_item_type noise_item();
      req_item_type it;
      it.req_type    = 1'($urandom_range(0, 1));
      it.start_x     = coord_type'($urandom);
      it.start_y     = coord_type'($urandom);
      it.end_x       = coord_type'($urandom);
      it.end_y       = coord_type'($urandom);
      it.line_colour = $urandom;
      return it;
   endfunction

   function automatic coord_type clamp_coord(input int v);
      if (v < 0) return '0;
      if (v > (1 << COORD_BITS) - 1) return '1;
      return coord_type'(v);
   endfunction

   // Offers one item, after an occasional random gap, and waits for its acceptance.
   task automatic put(input req_item_type it);
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.item  <= it;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent++;
      if (sent % 64 == 0) gap_odds = $urandom_range(0, 2) * 4;
      calm = (sent >= 1450);
   endtask

   task automatic step_only();
      req_item_type it;
      it = noise_item();
      it.req_type = REQ_STEP;
      put(it);
   endtask

   // Starts a line and asks for a number of further pixels.
   task automatic draw_line(input coord_type x0, input coord_type y0, input coord_type x1,
                            input coord_type y1, input colour_type c, input int nsteps);
      req_item_type it;
      it = noise_item();
      it.req_type    = REQ_START;
      it.start_x     = x0;
      it.start_y     = y0;
      it.end_x       = x1;
      it.end_y       = y1;
      it.line_colour = c;
      put(it);
      repeat (nsteps) step_only();
   endtask

   // Mostly short lines drawn to the end; some axis and diagonal lines, some long
   // ones, and some cut short by the next start.
   task automatic random_line();
      int        kind;
      int        reach;
      int        ox;
      int        oy;
      int        maj;
      int        nsteps;
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
      kind = $urandom_range(0, 99);
      x0   = coord_type'($urandom);
      y0   = coord_type'($urandom);
      if (kind < 6) begin
         x1 = coord_type'($urandom);
         y1 = coord_type'($urandom);
      end else begin
         if (kind < 20) begin
            reach = $urandom_range(0, 24);
            case ($urandom_range(0, 2))
               0: begin
                  ox = reach;
                  oy = 0;
               end
               1: begin
                  ox = 0;
                  oy = reach;
               end
               default: begin
                  ox = reach;
                  oy = reach;
               end
            endcase
            if ($urandom_range(0, 1) == 1) ox = -ox;
            if ($urandom_range(0, 1) == 1) oy = -oy;
         end else begin
            reach = (kind < 88) ? 12 : 150;
            ox = int'($urandom_range(0, 2 * reach)) - reach;
            oy = int'($urandom_range(0, 2 * reach)) - reach;
         end
         x1 = clamp_coord(int'(x0) + ox);
         y1 = clamp_coord(int'(y0) + oy);
      end
      ox  = int'(x1) - int'(x0);
      oy  = int'(y1) - int'(y0);
      ox  = (ox < 0) ? -ox : ox;
      oy  = (oy < 0) ? -oy : oy;
      maj = (ox > oy) ? ox : oy;
      if (maj <= 250 && $urandom_range(0, 4) != 0) begin
         nsteps = maj;
      end else begin
         nsteps = $urandom_range(0, (maj < 40) ? maj : 40);
      end
      draw_line(x0, y0, x1, y1, $urandom, nsteps);
      // Now and then keep stepping past the end of a finished line.
      if (nsteps == maj && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) step_only();
      end
   endtask

   // Result side: ready with random stall bursts, in phases of differing density.
   initial begin
      int unsigned tick;
      tick = 0;
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 200 == 0) stall_odds = $urandom_range(0, 2) * 4;
         if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Request side and verdict.
   initial begin
      int dx[8];
      int dy[8];
      bit drained;
      dx = '{3, 1, -1, -3, -3, -1, 1, 3};
      dy = '{-1, -3, -3, -1, 1, 3, 3, 1};
      drained = 1'b0;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.item  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: step with nothing running, a single-pixel line, corner to corner
      // diagonals, a start while a line is running, and one line in each octant.
      step_only();
      draw_line('1, '1, '1, '1, 32'hFFFF_FFFF, 0);
      step_only();
      draw_line('0, '0, '1, '1, 32'h0000_0000, 2);
      draw_line('0, '1, '1, '0, 32'hA5A5_5A5A, 1);
      for (int i = 0; i < 8; i++) begin
         draw_line(coord_type'(2048), coord_type'(2048), coord_type'(2048 + dx[i]),
                   coord_type'(2048 + dy[i]), $urandom, 1);
      end
      draw_line(coord_type'(0), coord_type'(2047), coord_type'(2), coord_type'(2047),
                32'h5A5A_A5A5, 2);
      step_only();

      // Random lines; once, halfway, let every pixel come out before going on.
      gap_odds = 4;
      while (sent < 1600) begin
         if (!drained && sent >= 800) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (pending != 0);
            drained = 1'b1;
         end
         random_line();
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (6) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_midpoint_line_rasterizer_core: clean");
      end else begin
         $display("tb_midpoint_line_rasterizer_core: errors");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #3000000;
      $display("tb_midpoint_line_rasterizer_core: errors");
      $finish;
   end

endmodule
